// ----- hdl/pshb_pkg.sv -----
// Package: shared constants, types and back-end state encoding for the PJW bucket hash.
package pshb_pkg;

   localparam int KEY_W       = 8;
   localparam int HASH_W      = 32;
   localparam int PJW_SHIFT   = 4;
   localparam int FOLD_W      = HASH_W - PJW_SHIFT;   // folded hash never has its top nibble set
   localparam int FOLD_POS    = 4;                    // top nibble is XORed back in at bit 4
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_CNT_W   = $clog2(FOLD_W);

   localparam logic [HASH_W-1:0] TABLE_SIZE_RESET = HASH_W'(1024);

   typedef struct packed {
      logic              push;
      logic [FOLD_W-1:0] hash;
   } hash_push_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [FOLD_W-1:0] head;
   } queue_status_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_DONE
   } back_state_type;

endpackage

// ----- hdl/pshb_if.sv -----
// Interfaces: key byte input, bucket result output and table size write channel.
interface pshb_req_if;
   import pshb_pkg::*;
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_byte;
   logic             last_byte;
   modport source (output valid, output key_byte, output last_byte, input ready);
   modport sink   (input valid, input key_byte, input last_byte, output ready);
endinterface

interface pshb_rsp_if;
   import pshb_pkg::*;
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] bucket_index;
   modport source (output valid, output bucket_index, input ready);
   modport sink   (input valid, input bucket_index, output ready);
endinterface

interface pshb_csr_if;
   import pshb_pkg::*;
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] table_size;
   modport source (output valid, output table_size, input ready);
   modport sink   (input valid, input table_size, output ready);
endinterface

// ----- hdl/pjw_string_hash_bucket_top.sv -----
// Top level: PJW string hash of a byte-serial key, reduced modulo a table size.
// Result path: the last key word's hash goes into the hash queue; the back end, once idle,
// pops it, runs the remainder and registers the bucket index for rsp_chan.
// Throughput: one key word per cycle while the hash queue is not full; the back end's
// bit-serial remainder works on one key at a time, so short keys are paced by the divider.
// The hash queue holds QUEUE_DEPTH finished keys so the front keeps taking bytes.
// Reset (synchronous, active high) clears the hash, empties the queue, sets table size to 1024.
module pjw_string_hash_bucket_top #(
   parameter int QUEUE_DEPTH = pshb_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   pshb_req_if.sink   req_chan,
   pshb_rsp_if.source rsp_chan,
   pshb_csr_if.sink   csr_chan
);
   import pshb_pkg::*;

   hash_push_type    push;      // finished key hash from the front
   queue_status_type q_status;  // queue occupancy and head word
   logic             pop;

   // front: one key word per cycle, stalls only while the queue is full
   pshb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .queue_full (q_status.full),
      .push_out   (push)
   );

   // decouples byte folding from the multi-cycle modulo
   pshb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .status  (q_status)
   );

   // back: remainder unit, table size register and result register
   pshb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_chan),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

// ----- hdl/pshb_front.sv -----
// Front end: takes key bytes and folds them into the running PJW hash.
module pshb_front (
   input  logic                    clock,
   input  logic                    reset,
   pshb_req_if.sink                req,
   input  logic                    queue_full,
   output pshb_pkg::hash_push_type push_out
);
   import pshb_pkg::*;

   logic [FOLD_W-1:0] hash_ff, hash_in;
   logic [HASH_W-1:0] sum;
   logic [PJW_SHIFT-1:0] top;
   logic [FOLD_W-1:0] folded;
   logic              accept;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      sum    = {hash_ff, {PJW_SHIFT{1'b0}}} + HASH_W'(req.key_byte);
      top    = sum[HASH_W-1 -: PJW_SHIFT];
      folded = sum[FOLD_W-1:0] ^ (FOLD_W'(top) << FOLD_POS);
   end

   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         hash_in = req.last_byte ? '0 : folded;
      end
   end

   assign push_out.push = accept && req.last_byte;
   assign push_out.hash = folded;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

`ifndef ASSERT_OFF
   a_hash_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req.last_byte) |=> (hash_ff == '0))
      else $error("running hash not cleared after last byte");
`endif

endmodule

// ----- hdl/pshb_queue.sv -----
// Queue: short FIFO of finished key hashes between front and back ends.
module pshb_queue #(
   parameter int DEPTH = pshb_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pshb_pkg::hash_push_type    push_in,
   input  logic                       pop,
   output pshb_pkg::queue_status_type status
);
   import pshb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [FOLD_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.head  = mem[rd_ptr_ff];

   assign do_push = push_in.push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_in.hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_in.push |-> !status.full)
      else $error("hash pushed into full queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");
`endif

endmodule

// ----- hdl/pshb_back.sv -----
// Back end: bit-serial modulo of each key hash by table size, plus result register.
module pshb_back (
   input  logic                       clock,
   input  logic                       reset,
   pshb_csr_if.sink                   csr,
   input  pshb_pkg::queue_status_type q_status,
   output logic                       pop,
   pshb_rsp_if.source                 rsp
);
   import pshb_pkg::*;

   back_state_type       state_ff, state_in;
   logic [HASH_W-1:0]    table_size_ff, table_size_in;
   logic [HASH_W-1:0]    div_ff, div_in;
   logic [FOLD_W-1:0]    dvd_ff, dvd_in;
   logic [HASH_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [HASH_W-1:0]    out_data_ff, out_data_in;
   logic [HASH_W:0]      shifted;
   logic                 start, step, load;

   assign csr.ready     = 1'b1;
   assign table_size_in = (csr.valid && csr.ready) ? csr.table_size : table_size_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) state_in = B_DIV;
         end
         B_DIV: begin
            if (cnt_ff == '0) state_in = B_DONE;
         end
         B_DONE: begin
            if (!out_valid_ff || rsp.ready) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      start = 1'b0;
      step  = 1'b0;
      load  = 1'b0;
      case (state_ff)
         B_IDLE:  start = !q_status.empty;
         B_DIV:   step  = 1'b1;
         B_DONE:  load  = !out_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   assign pop = start;

   // restoring remainder, one dividend bit per cycle, MSB first
   always_comb begin
      shifted = {rem_ff, dvd_ff[FOLD_W-1]};
      div_in  = div_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         div_in = table_size_ff;
         dvd_in = q_status.head;
         rem_in = '0;
         cnt_in = DIV_CNT_W'(FOLD_W - 1);
      end else if (step) begin
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = HASH_W'(shifted - {1'b0, div_ff});
         end else begin
            rem_in = shifted[HASH_W-1:0];
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_data_in  = (div_ff == '0) ? '0 : rem_ff;   // zero table size gives bucket 0
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.bucket_index = out_data_ff;

   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         table_size_ff <= TABLE_SIZE_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         out_valid_ff  <= out_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV && div_ff != '0) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");
`endif

endmodule

// ----- dv/pjw_string_hash_bucket_top_tb.sv -----
// Testbench for the PJW bucket hash: random and directed keys, checked against a local hash predictor.
module pjw_string_hash_bucket_top_tb;
   import pshb_pkg::*;

   // Run shape
   localparam int PHASES          = 10;
   localparam int WORDS_PER_PHASE = 183;
   localparam int SETTLE_CYCLES   = FOLD_W + 12;   // covers the divider latency with margin
   localparam int CYCLE_LIMIT     = 600000;

   typedef struct packed {
      logic [KEY_W-1:0] key_byte;
      logic             last_byte;
   } key_word_type;

   // Receiver behavior, picked per phase
   typedef enum logic [1:0] {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_PATTERN,
      RSP_LONG_STALL
   } rsp_mode_type;

   logic clock;
   logic reset;

   pshb_req_if req_if ();
   pshb_rsp_if rsp_if ();
   pshb_csr_if csr_if ();

   pjw_string_hash_bucket_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Words waiting for the driver, and bucket indexes waiting for the DUT
   key_word_type      word_q[$];
   logic [HASH_W-1:0] bucket_expect_q[$];

   // Predictor state: running hash of the open key and the table size in force
   logic [HASH_W-1:0] key_hash;
   logic [HASH_W-1:0] table_size_model;

   int           words_queued;
   int           words_accepted;
   int           fail_count;
   int           cycle_count;
   logic         req_taken;
   int           burst_left;
   int           gap_left;
   logic         sender_gaps;
   rsp_mode_type rsp_mode;
   logic [15:0]  stall_pattern;
   logic [3:0]   pattern_pos;
   int           stall_left;

   logic [HASH_W-1:0] phase_size [PHASES];
   logic [HASH_W-1:0] bucket_exp;

   always #10 clock = ~clock;

   // One PJW step: shift in the byte, fold the top nibble back in at bit 4, clear it.
   function automatic logic [HASH_W-1:0] pjw_fold_byte(input logic [HASH_W-1:0] h,
                                                       input logic [KEY_W-1:0]  b);
      logic [HASH_W-1:0]    sum;
      logic [PJW_SHIFT-1:0] top;
      sum = (h << PJW_SHIFT) + HASH_W'(b);
      top = sum[HASH_W-1 -: PJW_SHIFT];
      if (top != '0) begin
         sum = (sum ^ (HASH_W'(top) << FOLD_POS)) & {{PJW_SHIFT{1'b0}}, {FOLD_W{1'b1}}};
      end
      return sum;
   endfunction

   task automatic queue_word(input logic [KEY_W-1:0] b, input logic fin);
      key_word_type w;
      w.key_byte  = b;
      w.last_byte = fin;
      word_q.push_back(w);
      words_queued++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         queue_word(s[i], i == s.len() - 1);
      end
   endtask

   // Random key: mostly short keys, some long ones that fold the top nibble many times
   task automatic queue_random_key();
      int               len;
      int               pick;
      int               flavor;
      logic [KEY_W-1:0] b;
      pick   = $urandom_range(0, 99);
      len    = (pick < 75) ? $urandom_range(1, 8) :
               (pick < 95) ? $urandom_range(9, 24) : $urandom_range(25, 64);
      flavor = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
         case (flavor)
            6, 7: b = KEY_W'($urandom_range(32, 126));     // printable text
            8: begin                                       // zero bytes and all-ones mixed in
               pick = $urandom_range(0, 2);
               b = (pick == 0) ? '0 : (pick == 1) ? '1 : KEY_W'($urandom);
            end
            9: b = KEY_W'($urandom_range(240, 255));       // high nibble always set
            default: b = KEY_W'($urandom);
         endcase
         queue_word(b, i == len - 1);
      end
   endtask

   // Directed keys: byte extremes, zeros inside a key, a key long enough to fold
   task automatic queue_directed();
      queue_word(8'h00, 1'b1);
      queue_word(8'hFF, 1'b1);
      queue_word(8'h41, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'h42, 1'b1);
      for (int i = 0; i < 8; i++) begin
         queue_word(8'hFF, i == 7);
      end
      queue_text("pjw_hash");
      queue_word(8'h80, 1'b0);
      queue_word(8'h01, 1'b0);
      queue_word(8'h7F, 1'b1);
   endtask

   // Table size write; only called with the block idle
   task automatic write_table_size(input logic [HASH_W-1:0] v);
      @(negedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.table_size <= v;
      do begin
         @(posedge clock);
      end while (!(csr_if.valid && csr_if.ready));
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Blocks until every queued word is taken and every bucket index has come back
   task automatic wait_for_drain();
      while (words_accepted != words_queued || bucket_expect_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of random length, with random gaps when sender_gaps is set, fed from word_q.
   // A word on the bus stays put until the edge that takes it.
   always @(negedge clock) begin
      if (!req_if.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (word_q.size() > 0) begin
            req_if.valid     <= 1'b1;
            req_if.key_byte  <= word_q[0].key_byte;
            req_if.last_byte <= word_q[0].last_byte;
            void'(word_q.pop_front());
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
            end
            burst_left--;
            if (burst_left == 0 && sender_gaps) begin
               gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                                                        $urandom_range(1, 8);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: ready pattern depends on the phase
   always @(negedge clock) begin
      case (rsp_mode)
         RSP_ALWAYS: rsp_if.ready <= 1'b1;
         RSP_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
         RSP_PATTERN: begin
            rsp_if.ready <= stall_pattern[pattern_pos];
            pattern_pos  <= pattern_pos + 1'b1;
         end
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(5, 40);
               end
            end
         end
      endcase
   end

   // Monitor: table size writes, accepted key words (predictor) and returned bucket indexes
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pjw_string_hash_bucket_top regression: fail");
         $finish;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (!reset) begin
            if (csr_if.valid && csr_if.ready) begin
               table_size_model = csr_if.table_size;
            end
            if (req_if.valid && req_if.ready) begin
               words_accepted++;
               key_hash = pjw_fold_byte(key_hash, req_if.key_byte);
               if (req_if.last_byte) begin
                  // zero table size gives bucket 0
                  bucket_expect_q.push_back((table_size_model == '0) ? '0 :
                                            key_hash % table_size_model);
                  key_hash = '0;
               end
            end
            if (rsp_if.valid && rsp_if.ready) begin
               if (bucket_expect_q.size() == 0) begin
                  $error("bucket_index: unexpected result %0d, nothing pending",
                         rsp_if.bucket_index);
                  fail_count++;
               end else begin
                  bucket_exp = bucket_expect_q.pop_front();
                  if (rsp_if.bucket_index !== bucket_exp) begin
                     $error("bucket_index: expected %0d, actual %0d",
                            bucket_exp, rsp_if.bucket_index);
                     fail_count++;
                  end
               end
            end
         end
      end
   end

   // Sequencer: reset, then one phase per table size. Each phase ends on a key
   // boundary and the sender holds off until every bucket index is back, so the
   // next table size write lands on an idle block.
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.key_byte   = '0;
      req_if.last_byte  = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.table_size = '0;
      key_hash          = '0;
      table_size_model  = TABLE_SIZE_RESET;
      words_queued      = 0;
      words_accepted    = 0;
      fail_count        = 0;
      cycle_count       = 0;
      req_taken         = 1'b0;
      burst_left        = 0;
      gap_left          = 0;
      sender_gaps       = 1'b1;
      rsp_mode          = RSP_ALWAYS;
      stall_pattern     = 16'hFFFF;
      pattern_pos       = '0;
      stall_left        = 0;

      // Phase 0 runs on the reset table size; the rest cover 1, 0, the top of the
      // range, sizes around 2^FOLD_W, 37, random values and the reset size again.
      phase_size = '{TABLE_SIZE_RESET, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'h1000_0000,
                     32'h0FFF_FFFF, 32'd37, 32'd0, 32'd0, TABLE_SIZE_RESET};
      phase_size[7] = $urandom;
      phase_size[8] = $urandom_range(2, 300);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            write_table_size(phase_size[p]);
         end
         @(posedge clock);
         sender_gaps   = (p % 3 != 2);     // every third phase runs back to back
         rsp_mode      = rsp_mode_type'(p % 4);
         stall_pattern = 16'($urandom) | 16'h0101;
         if (p == 0) begin
            queue_directed();
         end
         begin
            int stop_at;
            stop_at = words_queued + WORDS_PER_PHASE;
            while (words_queued < stop_at) begin
               queue_random_key();
            end
         end
         wait_for_drain();
      end

      if (fail_count == 0) begin
         $display("pjw_string_hash_bucket_top regression: pass");
      end else begin
         $display("pjw_string_hash_bucket_top regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/pshb_pkg.sv
hdl/pshb_if.sv
hdl/pshb_front.sv
hdl/pshb_queue.sv
hdl/pshb_back.sv
hdl/pjw_string_hash_bucket_top.sv
dv/pjw_string_hash_bucket_top_tb.sv
